// File: hdl/dwt_pkg.sv
// shared types, codes and saturating helpers for the demon window tally
package dwt_pkg;

  localparam int POS_W    = 32;
  localparam int VEL_W    = 16;
  localparam int MASS_W   = 16;
  localparam int SUM_W    = 32;
  localparam int PROD_W   = MASS_W + SUM_W;
  localparam int KE_SHIFT = 9;
  localparam int KE_W     = PROD_W - KE_SHIFT;
  localparam int CNT_W    = 13;
  localparam int EN_W     = 60;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 296;

  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
  localparam logic [EN_W-1:0]  ENERGY_MAX = {EN_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_DIRECTION = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENERGY    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NUMBER    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_MASS,
    ST_TALLY,
    ST_EMIT
  } state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic              en;
    logic [MASS_W-1:0] op_a;
    logic [SUM_W-1:0]  op_b;
  } mul_req_t;

  function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
    cnt_inc = (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic [EN_W-1:0] en_add(input logic [EN_W-1:0] a,
                                             input logic [KE_W-1:0] b);
    logic [EN_W:0] s;
    s = {1'b0, a} + (EN_W+1)'(b);
    en_add = s[EN_W] ? ENERGY_MAX : s[EN_W-1:0];
  endfunction

endpackage

// File: hdl/dwt_mul.sv
// shared registered multiplier for squares and the mass product
module dwt_mul
  import dwt_pkg::*;
(
  input  logic              clk,
  input  mul_req_t          req,
  output logic [PROD_W-1:0] prod
);

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
    end
  end

  assign prod = prod_r;

endmodule

// File: hdl/demon_window_tally.sv
// top level: particle crossing and side tally with demon door decision
//
// channel | dir | handshake          | payload
// in_     | in  | tvalid/tready      | tdata: particle record, tlast: ends window
// out_    | out | tvalid/tready      | tdata: window totals and keep_open
// cfg_    | in  | wr_en              | index, wdata
//
// an item is taken only in the idle state, then its velocity components are
// squared and summed in the single shared multiplier, then the mass product is
// formed in it, then the item is tallied; a zero-mass item skips to the tally
// step and is not counted. the item ending a window then loads the result
// register, waiting while an earlier result is still held by out_tready low.
// rst_n clears tallies, registers and control; payload registers are not reset.
module demon_window_tally
  import dwt_pkg::*;
#(
  parameter int DIMS = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // position_x, velocity_x, velocity_y, velocity_z, particle_mass, prev_side
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  logic                    in_tlast,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // keep_open, to_right_count, to_left_count, to_right_energy, to_left_energy,
  // left_count, right_count, left_energy, right_energy
  output logic [OUT_DATA_W-1:0]   out_tdata,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam logic [1:0] LAST_STEP = 2'(DIMS);

  state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  logic [POS_W-1:0]  partition_r;
  logic [MODE_W-1:0] mode_r;

  logic [VEL_W-1:0]  vx_r, vy_r, vz_r;
  logic [MASS_W-1:0] mass_r;
  logic              side_r, prev_r, last_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  logic [CNT_W-1:0] to_right_tally_r, to_left_tally_r, left_tally_r, right_tally_r;
  logic [EN_W-1:0]  to_right_en_r, to_left_en_r, left_en_r, right_en_r;

  logic             out_valid_r;
  logic             keep_r;
  logic [CNT_W-1:0] o_trc_r, o_tlc_r, o_lc_r, o_rc_r;
  logic [EN_W-1:0]  o_tre_r, o_tle_r, o_le_r, o_re_r;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;
  logic [VEL_W-1:0]  vsel;
  logic [VEL_W-1:0]  vabs;
  logic [KE_W-1:0]   ke;
  logic              accept;
  logic              do_tally;
  logic              do_emit;
  logic              keep;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign ke        = prod[PROD_W-1:KE_SHIFT];

  dwt_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  always_comb begin
    unique case (step_r)
      2'd0:    vsel = vx_r;
      2'd1:    vsel = vy_r;
      default: vsel = vz_r;
    endcase
    vabs = vsel[VEL_W-1] ? VEL_W'(-vsel) : vsel;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    sum_nxt   = sum_r;
    mul_req   = '{en: 1'b0, op_a: vabs, op_b: SUM_W'(vabs)};
    do_tally  = 1'b0;
    do_emit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          step_nxt  = 2'd0;
          state_nxt = (in_tdata[95:80] == '0) ? ST_TALLY : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // square issued this step, previous square accumulated
        mul_req.en = (step_r < LAST_STEP);
        sum_nxt    = (step_r == 2'd0) ? '0 : sum_r + prod[SUM_W-1:0];
        step_nxt   = step_r + 2'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_MASS;
        end
      end
      ST_MASS: begin
        mul_req   = '{en: 1'b1, op_a: mass_r, op_b: sum_r};
        state_nxt = ST_TALLY;
      end
      ST_TALLY: begin
        do_tally  = (mass_r != '0);
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          do_emit   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partition_r <= '0;
      mode_r      <= MODE_DIRECTION;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_PARTITION) begin
        partition_r <= cfg_wdata;
      end else if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_wdata[MODE_W-1:0];
      end
    end
  end

  // item capture and square sum
  always_ff @(posedge clk) begin
    if (accept) begin
      vx_r   <= in_tdata[47:32];
      vy_r   <= in_tdata[63:48];
      vz_r   <= in_tdata[79:64];
      mass_r <= in_tdata[95:80];
      prev_r <= in_tdata[96];
      last_r <= in_tlast;
      side_r <= !($signed(in_tdata[31:0]) <= $signed(partition_r));
    end
    sum_r <= sum_nxt;
  end

  always_comb begin
    unique case (mode_r)
      MODE_ENERGY: keep = (to_right_en_r >= to_left_en_r);
      MODE_NUMBER: keep = (to_right_tally_r >= to_left_tally_r);
      default:     keep = (to_left_tally_r == '0) && (to_left_en_r == '0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || do_emit) begin
      to_right_tally_r <= '0;
      to_left_tally_r  <= '0;
      left_tally_r     <= '0;
      right_tally_r    <= '0;
      to_right_en_r    <= '0;
      to_left_en_r     <= '0;
      left_en_r        <= '0;
      right_en_r       <= '0;
    end else if (do_tally) begin
      if (side_r != prev_r) begin
        if (side_r) begin
          to_right_tally_r <= cnt_inc(to_right_tally_r);
          to_right_en_r    <= en_add(to_right_en_r, ke);
        end else begin
          to_left_tally_r <= cnt_inc(to_left_tally_r);
          to_left_en_r    <= en_add(to_left_en_r, ke);
        end
      end
      if (side_r) begin
        right_tally_r <= cnt_inc(right_tally_r);
        right_en_r    <= en_add(right_en_r, ke);
      end else begin
        left_tally_r <= cnt_inc(left_tally_r);
        left_en_r    <= en_add(left_en_r, ke);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (do_emit) begin
      keep_r  <= keep;
      o_trc_r <= to_right_tally_r;
      o_tlc_r <= to_left_tally_r;
      o_tre_r <= to_right_en_r;
      o_tle_r <= to_left_en_r;
      o_lc_r  <= left_tally_r;
      o_rc_r  <= right_tally_r;
      o_le_r  <= left_en_r;
      o_re_r  <= right_en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_re_r, o_le_r, o_rc_r, o_lc_r,
                       o_tle_r, o_tre_r, o_tlc_r, o_trc_r, keep_r};

  // crossings into a side never outnumber the particles on that side
  a_right_bound: assert property (@(posedge clk) disable iff (!rst_n)
    to_right_tally_r <= right_tally_r && to_right_en_r <= right_en_r)
    else $error("left-to-right tally exceeds right side tally");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    to_left_tally_r <= left_tally_r && to_left_en_r <= left_en_r)
    else $error("right-to-left tally exceeds left side tally");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("ready stayed high after an item was taken");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside the emit step");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |=> (left_tally_r == '0 && right_tally_r == '0 && left_en_r == '0))
    else $error("tallies not cleared after result");

endmodule
